>>> hdl/ocp_pkg.sv
// shared types, constants and the arctangent table of the orbit camera position block
package ocp_pkg;

	localparam int ANGLE_BITS_DEF = 16;
	localparam int SINE_BITS_DEF  = 16;

	localparam int IN_W      = 16;
	localparam int OUT_W     = 17;
	localparam int GAIN_W    = 16;
	localparam int RADIUS_W  = 16;
	localparam int LIMIT_W   = 15;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;
	localparam int OUT_MAX   = 65535;

	localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORBIT_RADIUS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ELEVATION_LIMIT = 2'd2;

	localparam logic [GAIN_W-1:0]   TURN_GAIN_RST  = 16'd256;
	localparam logic [RADIUS_W-1:0] RADIUS_RST     = 16'd1536;
	localparam logic [LIMIT_W-1:0]  EL_LIMIT_RST   = 15'd16202;

	// trig operand select for the output scaler
	localparam logic [1:0] TRIG_SIN_AZ = 2'd0;
	localparam logic [1:0] TRIG_SIN_EL = 2'd1;
	localparam logic [1:0] TRIG_COS_AZ = 2'd2;

	// cordic gain in Q30
	localparam longint CORDIC_K_Q30 = 64'sd652032874;

	typedef struct packed {
		logic       load_in;
		logic       mul_en;
		logic       mul_dy;
		logic       upd_az;
		logic       upd_el;
		logic       cord_init;
		logic       cord_step;
		logic       cord_store;
		logic       cord_sel_el;
		logic       scale_mul;
		logic [1:0] mul_sel;
		logic       scale_res;
		logic       publish;
	} ocp_cmd_t;

	typedef struct packed {
		logic cord_last;
	} ocp_sts_t;

	// atan(2^-i) in units of 2^32 per turn
	function automatic logic [31:0] atan_entry(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:    v = 32'h20000000;
			5'd1:    v = 32'h12E4051E;
			5'd2:    v = 32'h09FB385B;
			5'd3:    v = 32'h051111D4;
			5'd4:    v = 32'h028B0D43;
			5'd5:    v = 32'h0145D7E1;
			5'd6:    v = 32'h00A2F61E;
			5'd7:    v = 32'h00517C55;
			5'd8:    v = 32'h0028BE53;
			5'd9:    v = 32'h00145F2F;
			5'd10:   v = 32'h000A2F98;
			5'd11:   v = 32'h000517CC;
			5'd12:   v = 32'h00028BE6;
			5'd13:   v = 32'h000145F3;
			5'd14:   v = 32'h0000A2FA;
			5'd15:   v = 32'h0000517D;
			5'd16:   v = 32'h000028BE;
			5'd17:   v = 32'h0000145F;
			5'd18:   v = 32'h00000A30;
			5'd19:   v = 32'h00000518;
			5'd20:   v = 32'h0000028C;
			5'd21:   v = 32'h00000146;
			5'd22:   v = 32'h000000A3;
			5'd23:   v = 32'h00000051;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

>>> hdl/ocp_datapath.sv
// datapath: angle update, shared cordic unit, output scaler and result registers
module ocp_datapath #(
	parameter int ANGLE_BITS = ocp_pkg::ANGLE_BITS_DEF,
	parameter int SINE_BITS  = ocp_pkg::SINE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ocp_pkg::ocp_cmd_t                   cmd,
	output ocp_pkg::ocp_sts_t                   sts,
	input  logic signed [ocp_pkg::IN_W-1:0]     delta_x,
	input  logic signed [ocp_pkg::IN_W-1:0]     delta_y,
	input  logic                                cfg_we,
	input  logic [ocp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ocp_pkg::CFG_DAT_W-1:0]       cfg_data,
	output logic signed [ocp_pkg::OUT_W-1:0]    pos_x,
	output logic signed [ocp_pkg::OUT_W-1:0]    pos_y,
	output logic signed [ocp_pkg::OUT_W-1:0]    pos_z
);

	localparam int IN_W    = ocp_pkg::IN_W;
	localparam int OUT_W   = ocp_pkg::OUT_W;
	localparam int PROD_W  = IN_W + ocp_pkg::GAIN_W + 1;
	localparam int STEP_W  = PROD_W - 8;
	localparam int SUM_W   = ((ANGLE_BITS > STEP_W) ? ANGLE_BITS : STEP_W) + 1;
	localparam int ZW      = 34;
	localparam int XW      = SINE_BITS + 3;
	localparam int TW      = SINE_BITS + 2;
	localparam int MW      = TW + ocp_pkg::RADIUS_W + 1;
	localparam int SC_W    = MW - SINE_BITS;
	localparam int CNT_W   = $clog2(SINE_BITS);

	localparam logic signed [SUM_W-1:0] QUARTER  = SUM_W'(longint'(1) << (ANGLE_BITS - 2));
	localparam logic signed [XW-1:0]    X0       = XW'((ocp_pkg::CORDIC_K_Q30 +
		(longint'(1) << (29 - SINE_BITS))) >>> (30 - SINE_BITS));
	localparam logic signed [XW-1:0]    TRIG_MAX = XW'(longint'(1) << SINE_BITS);
	localparam logic signed [MW-1:0]    ROUND    = MW'(longint'(1) << (SINE_BITS - 1));
	localparam logic signed [SC_W-1:0]  POS_MAX  = SC_W'(ocp_pkg::OUT_MAX);
	localparam logic [CNT_W-1:0]        CNT_LAST = CNT_W'(SINE_BITS - 1);

	logic signed [IN_W-1:0]               dx_q, dy_q;
	logic [ocp_pkg::GAIN_W-1:0]           gain_q;
	logic [ocp_pkg::RADIUS_W-1:0]         radius_q;
	logic [ocp_pkg::LIMIT_W-1:0]          limit_q;
	logic [ANGLE_BITS-1:0]                az_q;
	logic signed [ANGLE_BITS-1:0]         el_q;
	logic signed [PROD_W-1:0]             prod_q;
	logic signed [XW-1:0]                 cx_q, cy_q;
	logic signed [ZW-1:0]                 cz_q;
	logic                                 neg_q;
	logic [CNT_W-1:0]                     cnt_q;
	logic signed [TW-1:0]                 sin_az_q, cos_az_q, sin_el_q;
	logic signed [MW-1:0]                 mul_q;
	logic signed [OUT_W-1:0]              res_x_q, res_y_q, res_z_q;
	logic signed [OUT_W-1:0]              pos_x_q, pos_y_q, pos_z_q;

	logic signed [IN_W-1:0]               mul_d;
	logic signed [STEP_W-1:0]             step;
	logic signed [SUM_W-1:0]              el_sum, lim_s, el_sat;
	logic [ANGLE_BITS-1:0]                ang_sel;
	logic [31:0]                          a32, a_rot;
	logic                                 flip;
	logic signed [XW-1:0]                 sh_x, sh_y, xf, yf, xs, ys;
	logic signed [ZW-1:0]                 atan_z;
	logic signed [TW-1:0]                 trig_op;
	logic signed [SC_W-1:0]               scaled, pos_sat;

	assign mul_d = cmd.mul_dy ? dy_q : dx_q;
	assign step  = prod_q[PROD_W-1:8];

	// elevation sum at full width, clamped to the limit
	always_comb begin
		el_sum = {{(SUM_W-ANGLE_BITS){el_q[ANGLE_BITS-1]}}, el_q} +
			{{(SUM_W-STEP_W){step[STEP_W-1]}}, step};
		lim_s = $signed({{(SUM_W-ocp_pkg::LIMIT_W){1'b0}}, limit_q});
		if (lim_s > QUARTER) begin
			lim_s = QUARTER;
		end
		if (el_sum > lim_s) begin
			el_sat = lim_s;
		end else if (el_sum < -lim_s) begin
			el_sat = -lim_s;
		end else begin
			el_sat = el_sum;
		end
	end

	// quadrant fold into the right half plane
	always_comb begin
		ang_sel = cmd.cord_sel_el ? el_q : az_q;
		a32     = {ang_sel, {(32-ANGLE_BITS){1'b0}}};
		flip    = a32[31] ^ a32[30];
		a_rot   = {a32[31] ^ flip, a32[30:0]};
	end

	always_comb begin
		sh_x   = cy_q >>> cnt_q;
		sh_y   = cx_q >>> cnt_q;
		atan_z = $signed({{(ZW-32){1'b0}}, ocp_pkg::atan_entry(5'(cnt_q))});
		xf     = neg_q ? -cx_q : cx_q;
		yf     = neg_q ? -cy_q : cy_q;
		if (xf > TRIG_MAX) begin
			xs = TRIG_MAX;
		end else if (xf < -TRIG_MAX) begin
			xs = -TRIG_MAX;
		end else begin
			xs = xf;
		end
		if (yf > TRIG_MAX) begin
			ys = TRIG_MAX;
		end else if (yf < -TRIG_MAX) begin
			ys = -TRIG_MAX;
		end else begin
			ys = yf;
		end
	end

	always_comb begin
		case (cmd.mul_sel)
			ocp_pkg::TRIG_SIN_AZ: trig_op = sin_az_q;
			ocp_pkg::TRIG_SIN_EL: trig_op = sin_el_q;
			default:              trig_op = cos_az_q;
		endcase
		scaled = mul_q[MW-1:SINE_BITS];
		if (scaled > POS_MAX) begin
			pos_sat = POS_MAX;
		end else if (scaled < -POS_MAX) begin
			pos_sat = -POS_MAX;
		end else begin
			pos_sat = scaled;
		end
	end

	assign sts.cord_last = (cnt_q == CNT_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= ocp_pkg::TURN_GAIN_RST;
			radius_q <= ocp_pkg::RADIUS_RST;
			limit_q  <= ocp_pkg::EL_LIMIT_RST;
			az_q     <= '0;
			el_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ocp_pkg::REG_TURN_GAIN:       gain_q   <= cfg_data;
					ocp_pkg::REG_ORBIT_RADIUS:    radius_q <= cfg_data;
					ocp_pkg::REG_ELEVATION_LIMIT: limit_q  <= cfg_data[ocp_pkg::LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.upd_az) begin
				az_q <= az_q + step[ANGLE_BITS-1:0];
			end
			if (cmd.upd_el) begin
				el_q <= el_sat[ANGLE_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			dx_q <= delta_x;
			dy_q <= delta_y;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_d * $signed({1'b0, gain_q});
		end
		if (cmd.cord_init) begin
			cx_q  <= X0;
			cy_q  <= '0;
			cz_q  <= {{(ZW-32){a_rot[31]}}, a_rot};
			neg_q <= flip;
			cnt_q <= '0;
		end else if (cmd.cord_step) begin
			if (!cz_q[ZW-1]) begin
				cx_q <= cx_q - sh_x;
				cy_q <= cy_q + sh_y;
				cz_q <= cz_q - atan_z;
			end else begin
				cx_q <= cx_q + sh_x;
				cy_q <= cy_q - sh_y;
				cz_q <= cz_q + atan_z;
			end
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.cord_store) begin
			if (cmd.cord_sel_el) begin
				sin_el_q <= ys[TW-1:0];
			end else begin
				sin_az_q <= ys[TW-1:0];
				cos_az_q <= xs[TW-1:0];
			end
		end
		if (cmd.scale_mul) begin
			mul_q <= $signed({1'b0, radius_q}) * trig_op + ROUND;
		end
		// results shift in x, y, z order
		if (cmd.scale_res) begin
			res_z_q <= pos_sat[OUT_W-1:0];
			res_y_q <= res_z_q;
			res_x_q <= res_y_q;
		end
		if (cmd.publish) begin
			pos_x_q <= res_x_q;
			pos_y_q <= res_y_q;
			pos_z_q <= res_z_q;
		end
	end

	assign pos_x = pos_x_q;
	assign pos_y = pos_y_q;
	assign pos_z = pos_z_q;

endmodule

>>> hdl/ocp_controller.sv
// controller: sequences angle update, two cordic passes, scaling and output transfer
module ocp_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  ocp_pkg::ocp_sts_t sts,
	output ocp_pkg::ocp_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_DX,
		ST_UPD_AZ,
		ST_UPD_EL,
		ST_AZ_INIT,
		ST_AZ_ITER,
		ST_AZ_DONE,
		ST_EL_INIT,
		ST_EL_ITER,
		ST_EL_DONE,
		ST_SC0,
		ST_SC1,
		ST_SC2,
		ST_SC3,
		ST_PUBLISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:    cmd.load_in = in_valid;
			ST_MUL_DX:  cmd.mul_en = 1'b1;
			ST_UPD_AZ: begin
				cmd.upd_az = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_dy = 1'b1;
			end
			ST_UPD_EL:  cmd.upd_el = 1'b1;
			ST_AZ_INIT: cmd.cord_init = 1'b1;
			ST_AZ_ITER: cmd.cord_step = 1'b1;
			ST_AZ_DONE: cmd.cord_store = 1'b1;
			ST_EL_INIT: begin
				cmd.cord_init   = 1'b1;
				cmd.cord_sel_el = 1'b1;
			end
			ST_EL_ITER: cmd.cord_step = 1'b1;
			ST_EL_DONE: begin
				cmd.cord_store  = 1'b1;
				cmd.cord_sel_el = 1'b1;
			end
			ST_SC0: begin
				cmd.scale_mul = 1'b1;
				cmd.mul_sel   = ocp_pkg::TRIG_SIN_AZ;
			end
			ST_SC1: begin
				cmd.scale_res = 1'b1;
				cmd.scale_mul = 1'b1;
				cmd.mul_sel   = ocp_pkg::TRIG_SIN_EL;
			end
			ST_SC2: begin
				cmd.scale_res = 1'b1;
				cmd.scale_mul = 1'b1;
				cmd.mul_sel   = ocp_pkg::TRIG_COS_AZ;
			end
			ST_SC3:     cmd.scale_res = 1'b1;
			ST_PUBLISH: cmd.publish = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_PUBLISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE:    if (in_valid) state_q <= ST_MUL_DX;
				ST_MUL_DX:  state_q <= ST_UPD_AZ;
				ST_UPD_AZ:  state_q <= ST_UPD_EL;
				ST_UPD_EL:  state_q <= ST_AZ_INIT;
				ST_AZ_INIT: state_q <= ST_AZ_ITER;
				ST_AZ_ITER: if (sts.cord_last) state_q <= ST_AZ_DONE;
				ST_AZ_DONE: state_q <= ST_EL_INIT;
				ST_EL_INIT: state_q <= ST_EL_ITER;
				ST_EL_ITER: if (sts.cord_last) state_q <= ST_EL_DONE;
				ST_EL_DONE: state_q <= ST_SC0;
				ST_SC0:     state_q <= ST_SC1;
				ST_SC1:     state_q <= ST_SC2;
				ST_SC2:     state_q <= ST_SC3;
				ST_SC3:     state_q <= ST_PUBLISH;
				ST_PUBLISH: if (out_free) state_q <= ST_IDLE;
				default:    state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> hdl/orbit_camera_position.sv
// top level of the orbit camera position block
// Each pointer-motion transfer scales delta_x and delta_y by turn_gain, wraps the azimuth,
// clamps the elevation to elevation_limit and returns the orbit position
// (r*sin az, r*sin el, r*cos az) in signed Q8.8. Each item is finished before the next input
// transfer is accepted: a single shared CORDIC unit runs SINE_BITS iterations for the
// azimuth and then for the elevation, and one multiplier scales the three results in turn.
// A finished position sits in the output register while the next item is accepted and
// worked on. The configuration port is always ready; writes take effect at once and are
// meant for idle periods.
module orbit_camera_position #(
	parameter int ANGLE_BITS = ocp_pkg::ANGLE_BITS_DEF,
	parameter int SINE_BITS  = ocp_pkg::SINE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [ocp_pkg::IN_W-1:0]  delta_x,
	input  logic signed [ocp_pkg::IN_W-1:0]  delta_y,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [ocp_pkg::OUT_W-1:0] pos_x,
	output logic signed [ocp_pkg::OUT_W-1:0] pos_y,
	output logic signed [ocp_pkg::OUT_W-1:0] pos_z,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ocp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ocp_pkg::CFG_DAT_W-1:0]    cfg_data
);

	ocp_pkg::ocp_cmd_t cmd;
	ocp_pkg::ocp_sts_t sts;
	logic              cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	ocp_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ocp_datapath #(
		.ANGLE_BITS (ANGLE_BITS),
		.SINE_BITS  (SINE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.delta_x   (delta_x),
		.delta_y   (delta_y),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z)
	);

endmodule

>>> hdl/ocp_checker.sv
// port-level checker for the orbit camera position block and its bind
module ocp_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [ocp_pkg::OUT_W-1:0] pos_x,
	input logic signed [ocp_pkg::OUT_W-1:0] pos_y,
	input logic signed [ocp_pkg::OUT_W-1:0] pos_z
);

	localparam logic signed [ocp_pkg::OUT_W-1:0] POS_MIN = {1'b1, {(ocp_pkg::OUT_W-1){1'b0}}};

	// a pending result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	// the block is busy right after an input transfer
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted again right after a transfer");

	// a new result only appears while the input side is closed
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without work in progress");

	// positions never reach the most negative code
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pos_x != POS_MIN && pos_y != POS_MIN && pos_z != POS_MIN)
		else $error("position out of saturation range");

endmodule

bind orbit_camera_position ocp_checker u_ocp_checker (.*);

>>> tb/orbit_camera_position_tb.sv
// self-checking testbench of the orbit camera position block with a scoreboard class
module orbit_camera_position_tb;
	import ocp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int QUARTER_TURN = 1 << (ANGLE_BITS_DEF - 2);
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS = 75;

	typedef struct packed {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic signed [OUT_W-1:0] z;
	} orbit_pos_t;

	class orbit_predictor;
		logic [GAIN_W-1:0]   turn_gain;
		logic [RADIUS_W-1:0] orbit_radius;
		logic [LIMIT_W-1:0]  elevation_limit;
		logic [15:0]         azimuth;
		int                  elevation;
		logic [31:0]         atan_q32 [16];
		orbit_pos_t          expected_positions [$];
		int                  errors;
		int                  positions_checked;

		function new();
			atan_q32 = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
				32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
				32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
				32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};
			turn_gain = TURN_GAIN_RST;
			orbit_radius = RADIUS_RST;
			elevation_limit = EL_LIMIT_RST;
			azimuth = '0;
			elevation = 0;
			errors = 0;
			positions_checked = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			case (idx)
				REG_TURN_GAIN:       turn_gain = data;
				REG_ORBIT_RADIUS:    orbit_radius = data;
				REG_ELEVATION_LIMIT: elevation_limit = data[LIMIT_W-1:0];
				default: ;
			endcase
		endfunction

		function longint clamp(longint v, longint m);
			if (v > m) return m;
			if (v < -m) return -m;
			return v;
		endfunction

		// angle in 2^32 units per turn
		function void sin_cos(logic [31:0] ang, output longint sn, output longint cs);
			logic [31:0] a;
			logic        flip;
			longint      x, y, z, sx, sy;
			a = ang;
			flip = 1'b0;
			if (a[31:30] == 2'b01 || a[31:30] == 2'b10) begin
				a = a + 32'h80000000;
				flip = 1'b1;
			end
			z = $signed(a);
			x = (CORDIC_K_Q30 + (64'sd1 << 13)) >>> 14;
			y = 0;
			for (int i = 0; i < 16; i++) begin
				sx = y >>> i;
				sy = x >>> i;
				if (z >= 0) begin
					x = x - sx;
					y = y + sy;
					z = z - longint'(atan_q32[i]);
				end else begin
					x = x + sx;
					y = y - sy;
					z = z + longint'(atan_q32[i]);
				end
			end
			if (flip) begin
				x = -x;
				y = -y;
			end
			sn = clamp(y, 64'sd1 << 16);
			cs = clamp(x, 64'sd1 << 16);
		endfunction

		function logic signed [OUT_W-1:0] scale(longint trig);
			longint r, p;
			r = orbit_radius;
			p = r * trig + (64'sd1 << 15);
			p = clamp(p >>> 16, OUT_MAX);
			return p[OUT_W-1:0];
		endfunction

		function void note_motion(logic signed [IN_W-1:0] dx, logic signed [IN_W-1:0] dy);
			longint     g, step, el_sum, lim, s_az, c_az, s_el, c_el;
			logic [15:0] el_bits;
			orbit_pos_t pos;
			g = turn_gain;
			step = (longint'(dx) * g) >>> 8;
			azimuth = azimuth + step[15:0];
			lim = (elevation_limit > QUARTER_TURN) ? QUARTER_TURN : elevation_limit;
			el_sum = longint'(elevation) + ((longint'(dy) * g) >>> 8);
			elevation = int'(clamp(el_sum, lim));
			el_bits = elevation[15:0];
			sin_cos({azimuth, 16'h0000}, s_az, c_az);
			sin_cos({el_bits, 16'h0000}, s_el, c_el);
			pos.x = scale(s_az);
			pos.y = scale(s_el);
			pos.z = scale(c_az);
			expected_positions.push_back(pos);
		endfunction

		function void check_position(logic signed [OUT_W-1:0] x, logic signed [OUT_W-1:0] y,
				logic signed [OUT_W-1:0] z);
			orbit_pos_t exp_pos;
			positions_checked++;
			if (expected_positions.size() == 0) begin
				$error("position transfer with none expected: %0d %0d %0d", x, y, z);
				errors++;
				return;
			end
			exp_pos = expected_positions.pop_front();
			if (x !== exp_pos.x) begin
				$error("pos_x expected %0d got %0d", exp_pos.x, x);
				errors++;
			end
			if (y !== exp_pos.y) begin
				$error("pos_y expected %0d got %0d", exp_pos.y, y);
				errors++;
			end
			if (z !== exp_pos.z) begin
				$error("pos_z expected %0d got %0d", exp_pos.z, z);
				errors++;
			end
		endfunction

		function int pending();
			return expected_positions.size();
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic signed [IN_W-1:0]  delta_x;
	logic signed [IN_W-1:0]  delta_y;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [OUT_W-1:0] pos_x;
	logic signed [OUT_W-1:0] pos_y;
	logic signed [OUT_W-1:0] pos_z;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DAT_W-1:0]    cfg_data;

	orbit_predictor board = new();
	logic           quiet = 1'b0;
	logic           long_hold_done = 1'b0;

	orbit_camera_position dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.delta_x  (delta_x),
		.delta_y  (delta_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_position(pos_x, pos_y, pos_z);
	end

	initial begin : receiver
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!long_hold_done && board.positions_checked >= 60) begin
				// long stall so the block fills up and drops in_ready
				long_hold_done = 1'b1;
				hold_left = 399;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				hold_left = $urandom_range(0, 8);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_motion(input logic signed [IN_W-1:0] dx,
			input logic signed [IN_W-1:0] dy);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid <= 1'b1;
		delta_x <= dx;
		delta_y <= dy;
		do @(posedge clk); while (!in_ready);
		board.note_motion(dx, dy);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] data);
		in_valid <= 1'b0;
		while (board.pending() != 0) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic signed [IN_W-1:0] rand_delta();
		int s;
		if ($urandom_range(0, 3) == 0)
			return IN_W'($urandom);
		s = int'($urandom_range(0, 800)) - 400;
		return s[IN_W-1:0];
	endfunction

	task automatic directed_items();
		send_motion(16'sd0, 16'sd0);
		send_motion(16'sd32767, 16'sd32767);
		send_motion(-16'sd32768, -16'sd32768);
		send_motion(16'sd16384, 16'sd0);
		send_motion(16'sd16384, 16'sd100);
		send_motion(16'sd16384, -16'sd100);
		write_reg(REG_TURN_GAIN, 16'd1);
		send_motion(-16'sd1, -16'sd1);
		send_motion(16'sd255, -16'sd255);
		write_reg(REG_TURN_GAIN, 16'd0);
		send_motion(16'sd32767, -16'sd32768);
		write_reg(REG_TURN_GAIN, 16'hFFFF);
		// elevation sum far past the limit
		send_motion(-16'sd32768, 16'sd32767);
		send_motion(16'sd32767, -16'sd32768);
		write_reg(REG_ORBIT_RADIUS, 16'd0);
		send_motion(16'sd3, 16'sd5);
		write_reg(REG_ORBIT_RADIUS, 16'hFFFF);
		write_reg(REG_TURN_GAIN, 16'd256);
		send_motion(16'sd0, 16'sd0);
		send_motion(-16'sd16384, 16'sd16384);
		write_reg(REG_ELEVATION_LIMIT, 16'd0);
		send_motion(16'sd1000, 16'sd1000);
		send_motion(-16'sd1000, -16'sd1000);
		write_reg(REG_ELEVATION_LIMIT, 16'd16384);
		send_motion(16'sd8192, 16'sd32767);
		// limit above a quarter turn
		write_reg(REG_ELEVATION_LIMIT, 16'd20000);
		send_motion(16'sd8192, 16'sd32767);
		write_reg(REG_ELEVATION_LIMIT, 16'hFFFF);
		send_motion(16'sd8192, -16'sd32768);
		// unused index is ignored
		write_reg(2'd3, 16'h1234);
		send_motion(16'sd77, 16'sd33);
	endtask

	task automatic random_phase(input int items);
		if ($urandom_range(0, 2) == 0)
			write_reg(REG_TURN_GAIN, CFG_DAT_W'($urandom));
		else
			write_reg(REG_TURN_GAIN, CFG_DAT_W'($urandom_range(0, 1024)));
		write_reg(REG_ORBIT_RADIUS, CFG_DAT_W'($urandom));
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_ELEVATION_LIMIT, CFG_DAT_W'($urandom));
		else
			write_reg(REG_ELEVATION_LIMIT, CFG_DAT_W'($urandom_range(0, QUARTER_TURN)));
		if ($urandom_range(0, 2) == 0)
			write_reg(2'd3, CFG_DAT_W'($urandom));
		repeat (items) send_motion(rand_delta(), rand_delta());
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		in_valid = 1'b0;
		delta_x = '0;
		delta_y = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		directed_items();
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == RANDOM_PHASES - 1)
				quiet = 1'b1;
			random_phase(PHASE_ITEMS);
		end
		in_valid <= 1'b0;
		while (board.pending() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> orbit_camera_position.f
hdl/ocp_pkg.sv
hdl/ocp_datapath.sv
hdl/ocp_controller.sv
hdl/orbit_camera_position.sv
hdl/ocp_checker.sv
tb/orbit_camera_position_tb.sv
